>>> design/tbt_pkg.sv
`default_nettype none
package tbt_pkg;

  // Outcome class of an item, settled as early as the pipeline can tell
  typedef enum logic [2:0] {
    K_OK,
    K_REF_ZERO,
    K_THERM_ZERO,
    K_SAT_LOW,
    K_SAT_HIGH
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_REF_ZERO   = 2'd1,
    ST_THERM_ZERO = 2'd2,
    ST_SATURATED  = 2'd3
  } status_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } side_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_REFERENCE_OHMS = 2'd0;
  localparam logic [1:0] CFG_BETA_KELVIN    = 2'd1;
  localparam logic [1:0] CFG_R_INFINITY     = 2'd2;

  localparam int unsigned NORM_W = 64;  // normalizer word
  localparam int unsigned Z_W    = 6;   // leading-zero count
  localparam int unsigned TAB_W  = 29;  // log2 table entry, Q28 up to 1.0
  localparam int unsigned LOG_W  = 35;  // log2 result, Q28 with 7 integer bits
  localparam int unsigned REM_W  = 53;  // divider partial remainder
  localparam int unsigned Q_W    = 18;  // quotient bits, centikelvin

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic signed [17:0] TEMP_MAX = 18'sd100000;
  localparam logic signed [17:0] ABS_ZERO = 18'sd27315;
  localparam logic [Q_W-1:0] CK_MAX = 18'd127315;

  // log2(1 + i / 2^bits) in Q28 by repeated squaring of a Q30 value
  function automatic logic [TAB_W-1:0] log2_entry(input int unsigned i,
                                                  input int unsigned bits);
    logic [63:0] y;
    logic [TAB_W-1:0] acc;
    y = (64'd1 << 30) + (64'(i) << (30 - bits));
    acc = '0;
    for (int b = 27; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        acc[b] = 1'b1;
      end
    end
    if (i >= (32'd1 << bits)) begin
      acc = TAB_W'(1) << 28;
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

>>> design/tbt_norm_cell.sv
`default_nettype none
module tbt_norm_cell #(
  parameter int unsigned SHIFT = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [tbt_pkg::NORM_W-1:0]  x_i,
  input  wire logic [tbt_pkg::Z_W-1:0]     z_i,
  output logic      [tbt_pkg::NORM_W-1:0]  x_o,
  output logic      [tbt_pkg::Z_W-1:0]     z_o
);

  logic                       top_zero;
  logic [tbt_pkg::NORM_W-1:0] x_d, x_q;
  logic [tbt_pkg::Z_W-1:0]    z_d, z_q;

  // Shift left when the top SHIFT bits are all clear
  always_comb begin
    top_zero = (x_i[tbt_pkg::NORM_W-1 -: SHIFT] == '0);
    x_d = top_zero ? (x_i << SHIFT) : x_i;
    z_d = top_zero ? (z_i + tbt_pkg::Z_W'(SHIFT)) : z_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign z_o = z_q;

endmodule
`default_nettype wire

>>> design/tbt_log.sv
`default_nettype none
module tbt_log #(
  parameter int unsigned TB = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [tbt_pkg::NORM_W-1:0]  x_i,
  input  wire logic [tbt_pkg::Z_W-1:0]     z_i,
  output logic      [tbt_pkg::LOG_W-1:0]   log_o
);

  localparam int unsigned N  = 2 ** TB;
  localparam int unsigned FS = 31 - TB;

  logic [tbt_pkg::TAB_W-1:0] tab [N+1];
  logic [TB:0]               idx;
  logic [FS-1:0]             rem;
  logic [tbt_pkg::TAB_W-1:0] lo, hi;
  logic [tbt_pkg::TAB_W-1:0] lo_q, dlt_q;
  logic [FS-1:0]             rem_q;
  logic [tbt_pkg::Z_W-1:0]   e_q;
  logic [tbt_pkg::TAB_W+FS-1:0] prod;
  logic [tbt_pkg::TAB_W-1:0] interp;
  logic [tbt_pkg::LOG_W-1:0] log_d, log_q;

  // Constant log2 table
  for (genvar g = 0; g <= N; g++) begin : g_tab
    assign tab[g] = tbt_pkg::log2_entry(g, TB);
  end

  // Look up both neighbors from the mantissa bits under the leading one
  always_comb begin
    idx = {1'b0, x_i[62 -: TB]};
    rem = x_i[62-TB -: FS];
    lo  = tab[idx];
    hi  = tab[idx + 1'b1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q  <= lo;
      dlt_q <= hi - lo;
      rem_q <= rem;
      e_q   <= ~z_i;
    end
  end

  // Interpolate and add the exponent
  always_comb begin
    prod   = tbt_pkg::TAB_W'(dlt_q) * (tbt_pkg::TAB_W+FS)'(rem_q);
    interp = tbt_pkg::TAB_W'(prod >> FS);
    log_d  = (tbt_pkg::LOG_W'(e_q) << 28) + tbt_pkg::LOG_W'(lo_q)
           + tbt_pkg::LOG_W'(interp);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      log_q <= log_d;
    end
  end

  assign log_o = log_q;

endmodule
`default_nettype wire

>>> design/tbt_div_cell.sv
`default_nettype none
module tbt_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire tbt_pkg::side_t             side_i,
  input  wire logic [tbt_pkg::REM_W-1:0]  rem_i,
  input  wire logic [tbt_pkg::Q_W-1:0]    quo_i,
  input  wire logic [tbt_pkg::LOG_W-1:0]  den_i,
  output tbt_pkg::side_t                  side_o,
  output logic      [tbt_pkg::REM_W-1:0]  rem_o,
  output logic      [tbt_pkg::Q_W-1:0]    quo_o,
  output logic      [tbt_pkg::LOG_W-1:0]  den_o
);

  logic [tbt_pkg::REM_W-1:0] shifted, rem_d, rem_q;
  logic [tbt_pkg::Q_W-1:0]   quo_d, quo_q;
  logic [tbt_pkg::LOG_W-1:0] den_q;
  logic                      valid_q;
  tbt_pkg::kind_e            kind_q;
  logic                      take;

  // One restoring step: subtract the shifted divisor when it fits
  always_comb begin
    shifted = tbt_pkg::REM_W'(den_i) << BIT;
    take    = (rem_i >= shifted);
    rem_d   = take ? (rem_i - shifted) : rem_i;
    quo_d   = quo_i;
    quo_d[BIT] = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q <= side_i.kind;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
    end
  end

  assign side_o = '{valid: valid_q, kind: kind_q};
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;
  assign den_o  = den_q;

endmodule
`default_nettype wire

>>> design/thermistor_beta_temperature_core.sv
// NTC thermistor temperature from a pair of ADC counts (beta equation).
// Input channel: in_valid_i with reference_count_i and thermistor_count_i;
// an item is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o with temperature_centi_c_o (signed hundredths
// of a degree C) and status_o; an item leaves when out_stall_i is low.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i
// (0 reference ohms, 1 beta, 2 r-infinity in micro-ohms); write while idle.
// Pipeline: a taken item passes two multiply stages, six leading-zero cells,
// two log-table stages, the log difference, the ln2 scaling, the divider
// setup and 18 divider cells, then the output register.
// Throughput: one item per cycle while in_stall_o is low; every stage registers.
// When the receiver stalls, the result waiting on the output is held and
// one more result lands in a skid register; then in_stall_o rises and the
// whole chain holds until the output drains.
// Reset empties the chain and output and loads the default constants
// (10000 ohms, beta 3380, r-infinity 0.119286 ohm).
`default_nettype none
module thermistor_beta_temperature_core #(
  parameter int unsigned ADC_BITS       = 12,
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [11:0]        reference_count_i,
  input  wire logic [11:0]        thermistor_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [17:0]      temperature_centi_c_o,
  output logic [1:0]              status_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [29:0]        cfg_data_i
);

  localparam int unsigned CNT_W = (ADC_BITS < 12) ? ADC_BITS : 12;
  localparam logic [11:0] CNT_MASK = 12'((32'd1 << CNT_W) - 32'd1);
  localparam int unsigned NMID = 8;

  logic [19:0] ohms_q;
  logic [13:0] beta_q;
  logic [29:0] rinf_q;

  logic        en;
  logic [11:0] rc_m, tc_m;
  tbt_pkg::kind_e kind1;
  tbt_pkg::kind_e kind_d, kind_m, kind_p;

  tbt_pkg::side_t side1_q, side2_q, side_d_q, side_m_q, side_p_q;
  tbt_pkg::side_t mid_side_q [NMID];
  logic [31:0] p1_q;
  logic [41:0] den1_q, den2_q;
  logic [51:0] num2_q;

  logic [tbt_pkg::NORM_W-1:0] nx [7];
  logic [tbt_pkg::Z_W-1:0]    nz [7];
  logic [tbt_pkg::NORM_W-1:0] dx [7];
  logic [tbt_pkg::Z_W-1:0]    dz [7];
  logic [tbt_pkg::LOG_W-1:0]  log_num, log_den;

  logic [tbt_pkg::LOG_W-1:0]  diff_q, ln_q, ln_d;
  logic [64:0]                ln_prod;
  logic [tbt_pkg::REM_W-1:0]  a_d;
  logic                       ovf;

  tbt_pkg::side_t             dside [19];
  logic [tbt_pkg::REM_W-1:0]  drem  [19];
  logic [tbt_pkg::Q_W-1:0]    dquo  [19];
  logic [tbt_pkg::LOG_W-1:0]  dden  [19];

  logic signed [17:0] fin_temp;
  logic [1:0]         fin_status;
  logic               out_valid_q, skid_valid_q;
  logic signed [17:0] out_temp_q, skid_temp_q;
  logic [1:0]         out_status_q, skid_status_q;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ohms_q <= 20'd10000;
      beta_q <= 14'd3380;
      rinf_q <= 30'd119286;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tbt_pkg::CFG_REFERENCE_OHMS: ohms_q <= cfg_data_i[19:0];
        tbt_pkg::CFG_BETA_KELVIN:    beta_q <= cfg_data_i[13:0];
        tbt_pkg::CFG_R_INFINITY:     rinf_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole chain advances unless the skid register is occupied
  assign en = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Classify special inputs up front
  always_comb begin
    rc_m = reference_count_i & CNT_MASK;
    tc_m = thermistor_count_i & CNT_MASK;
    priority if (rc_m == '0) begin
      kind1 = tbt_pkg::K_REF_ZERO;
    end else if (tc_m == '0 || ohms_q == '0) begin
      kind1 = tbt_pkg::K_THERM_ZERO;
    end else if (rinf_q == '0) begin
      kind1 = tbt_pkg::K_SAT_LOW;
    end else begin
      kind1 = tbt_pkg::K_OK;
    end
  end

  // Valid bits and outcome classes of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q  <= '{valid: 1'b0, kind: tbt_pkg::K_OK};
      side2_q  <= '{valid: 1'b0, kind: tbt_pkg::K_OK};
      side_d_q <= '{valid: 1'b0, kind: tbt_pkg::K_OK};
      side_m_q <= '{valid: 1'b0, kind: tbt_pkg::K_OK};
      side_p_q <= '{valid: 1'b0, kind: tbt_pkg::K_OK};
      for (int i = 0; i < NMID; i++) begin
        mid_side_q[i] <= '{valid: 1'b0, kind: tbt_pkg::K_OK};
      end
    end else if (en) begin
      side1_q  <= '{valid: in_valid_i, kind: kind1};
      side2_q  <= side1_q;
      mid_side_q[0] <= side2_q;
      for (int i = 1; i < NMID; i++) begin
        mid_side_q[i] <= mid_side_q[i-1];
      end
      side_d_q <= '{valid: mid_side_q[NMID-1].valid, kind: kind_d};
      side_m_q <= '{valid: side_d_q.valid, kind: kind_m};
      side_p_q <= '{valid: side_m_q.valid, kind: kind_p};
    end
  end

  // Form numerator and denominator of the resistance ratio
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= 32'(ohms_q) * 32'(tc_m);
      den1_q <= 42'(rc_m) * 42'(rinf_q);
      num2_q <= 52'(p1_q) * 52'd1000000;
      den2_q <= den1_q;
    end
  end

  // Leading-one search, one cell per shift size
  assign nx[0] = tbt_pkg::NORM_W'(num2_q);
  assign nz[0] = '0;
  assign dx[0] = tbt_pkg::NORM_W'(den2_q);
  assign dz[0] = '0;

  for (genvar g = 0; g < 6; g++) begin : g_norm
    tbt_norm_cell #(.SHIFT(32 >> g)) u_num (
      .clk_i(clk_i), .en_i(en), .x_i(nx[g]), .z_i(nz[g]),
      .x_o(nx[g+1]), .z_o(nz[g+1])
    );
    tbt_norm_cell #(.SHIFT(32 >> g)) u_den (
      .clk_i(clk_i), .en_i(en), .x_i(dx[g]), .z_i(dz[g]),
      .x_o(dx[g+1]), .z_o(dz[g+1])
    );
  end

  tbt_log #(.TB(LOG_TABLE_BITS)) u_log_num (
    .clk_i(clk_i), .en_i(en), .x_i(nx[6]), .z_i(nz[6]), .log_o(log_num)
  );
  tbt_log #(.TB(LOG_TABLE_BITS)) u_log_den (
    .clk_i(clk_i), .en_i(en), .x_i(dx[6]), .z_i(dz[6]), .log_o(log_den)
  );

  // Scale the log2 difference by ln2 with rounding, form the dividend, flag saturation
  always_comb begin
    ln_prod = 65'(diff_q) * 65'(tbt_pkg::LN2_Q30);
    ln_d    = tbt_pkg::LOG_W'((ln_prod + (65'd1 << 29)) >> 30);
    a_d     = (tbt_pkg::REM_W'(21'(beta_q) * 21'd100) << 28)
            + tbt_pkg::REM_W'(ln_q >> 1);
    ovf     = (a_d >= (tbt_pkg::REM_W'(ln_q) << tbt_pkg::Q_W));
    kind_d  = (mid_side_q[NMID-1].kind == tbt_pkg::K_OK && log_num < log_den)
              ? tbt_pkg::K_SAT_LOW : mid_side_q[NMID-1].kind;
    kind_m  = (side_d_q.kind == tbt_pkg::K_OK && ln_d == '0)
              ? tbt_pkg::K_SAT_HIGH : side_d_q.kind;
    kind_p  = (side_m_q.kind == tbt_pkg::K_OK && ovf)
              ? tbt_pkg::K_SAT_HIGH : side_m_q.kind;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q  <= log_num - log_den;
      ln_q    <= ln_d;
      drem[0] <= a_d;
      dquo[0] <= '0;
      dden[0] <= ln_q;
    end
  end

  assign dside[0] = side_p_q;

  // Divider chain, one quotient bit per cell, top bit first
  for (genvar g = 0; g < 18; g++) begin : g_div
    tbt_div_cell #(.BIT(17 - g)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .side_i(dside[g]), .rem_i(drem[g]), .quo_i(dquo[g]), .den_i(dden[g]),
      .side_o(dside[g+1]), .rem_o(drem[g+1]), .quo_o(dquo[g+1]),
      .den_o(dden[g+1])
    );
  end

  // Map the outcome to temperature and status
  always_comb begin
    unique case (dside[18].kind)
      tbt_pkg::K_OK: begin
        if (dquo[18] > tbt_pkg::CK_MAX) begin
          fin_temp   = tbt_pkg::TEMP_MAX;
          fin_status = tbt_pkg::ST_SATURATED;
        end else begin
          fin_temp   = signed'(dquo[18]) - tbt_pkg::ABS_ZERO;
          fin_status = tbt_pkg::ST_OK;
        end
      end
      tbt_pkg::K_REF_ZERO: begin
        fin_temp   = '0;
        fin_status = tbt_pkg::ST_REF_ZERO;
      end
      tbt_pkg::K_THERM_ZERO: begin
        fin_temp   = -tbt_pkg::ABS_ZERO;
        fin_status = tbt_pkg::ST_THERM_ZERO;
      end
      tbt_pkg::K_SAT_LOW: begin
        fin_temp   = -tbt_pkg::ABS_ZERO;
        fin_status = tbt_pkg::ST_SATURATED;
      end
      tbt_pkg::K_SAT_HIGH: begin
        fin_temp   = tbt_pkg::TEMP_MAX;
        fin_status = tbt_pkg::ST_SATURATED;
      end
      default: begin
        fin_temp   = tbt_pkg::TEMP_MAX;
        fin_status = tbt_pkg::ST_SATURATED;
      end
    endcase
  end

  // Output register with skid: drain skid first, else take the chain's item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= dside[18].valid;
      end
    end else if (dside[18].valid && en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_temp_q   <= skid_temp_q;
        out_status_q <= skid_status_q;
      end else begin
        out_temp_q   <= fin_temp;
        out_status_q <= fin_status;
      end
    end else if (en) begin
      skid_temp_q   <= fin_temp;
      skid_status_q <= fin_status;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign temperature_centi_c_o = out_temp_q;
  assign status_o              = out_status_q;

  // An occupied skid register always sits behind a valid output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output is empty");

  // Reference-zero results carry zero temperature
  a_ref_zero_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == tbt_pkg::ST_REF_ZERO) |-> (temperature_centi_c_o == '0))
    else $error("reference-zero result with nonzero temperature");

  // Good results stay within the saturation range
  a_ok_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == tbt_pkg::ST_OK) |->
      (temperature_centi_c_o >= -tbt_pkg::ABS_ZERO &&
       temperature_centi_c_o <= tbt_pkg::TEMP_MAX))
    else $error("unsaturated result out of range");

endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;

  localparam int unsigned TAB_BITS  = 8;
  localparam int unsigned FRAC_SH   = 31 - TAB_BITS;
  localparam longint unsigned LN2_FIX = 64'd744261118;
  localparam int KELVIN_OFS = 27315;
  localparam int HOT_LIMIT  = 100000;
  localparam int LATENCY    = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_PER_PHASE = 180;
  localparam int N_PHASES   = 6;

  typedef struct {
    logic [11:0]        rc;
    logic [11:0]        tc;
    bit                 typed;
    logic signed [17:0] temp;
    tbt_pkg::status_e   st;
  } stim_row_t;

  typedef struct {
    logic signed [17:0] temp;
    tbt_pkg::status_e   st;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [11:0] reference_count_i = '0;
  logic [11:0] thermistor_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [17:0] temperature_centi_c_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [29:0] cfg_data_i = '0;

  thermistor_beta_temperature_core u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and the log2 table
  longint unsigned ref_ohms, beta, r_inf_uohm;
  longint unsigned log2_tab[0:(1 << TAB_BITS)];

  reading_t expected_readings[$];
  int mismatches = 0;
  int items_sent = 0;
  int readings_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  function automatic void build_log2_tab();
    longint unsigned y;
    longint unsigned acc;
    for (int i = 0; i < (1 << TAB_BITS); i++) begin
      y = (64'd1 << 30) + (longint'(i) << (30 - TAB_BITS));
      acc = 0;
      for (int b = 27; b >= 0; b--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          acc |= (64'd1 << b);
        end
      end
      log2_tab[i] = acc;
    end
    log2_tab[1 << TAB_BITS] = 64'd1 << 28;
  endfunction

  // log2 of a nonzero value in Q28, table plus linear interpolation
  function automatic longint unsigned log2_fix(longint unsigned x);
    int e;
    longint unsigned m, frac, rem, lo, hi, interp;
    int idx;
    e = 63;
    while (e > 0 && x[e] == 1'b0) e--;
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    frac = m & 64'h7FFF_FFFF;
    idx = int'(frac >> FRAC_SH);
    rem = frac & ((64'd1 << FRAC_SH) - 1);
    lo = log2_tab[idx];
    hi = log2_tab[idx + 1];
    interp = (((hi - lo) & 64'hFFFF_FFFF) * rem) >> FRAC_SH;
    interp &= 64'hFFFF_FFFF;
    return (longint'(e) << 28) + lo + interp;
  endfunction

  function automatic reading_t thermistor_temp(logic [11:0] rc, logic [11:0] tc);
    reading_t r;
    longint unsigned num, den, ln_n, ln_d, ln_q, ck;
    if (rc == 0) begin
      r.temp = '0; r.st = tbt_pkg::ST_REF_ZERO; return r;
    end
    num = ref_ohms * tc * 64'd1000000;
    if (num == 0) begin
      r.temp = 18'(-KELVIN_OFS); r.st = tbt_pkg::ST_THERM_ZERO; return r;
    end
    den = rc * r_inf_uohm;
    if (den == 0) begin
      r.temp = 18'(-KELVIN_OFS); r.st = tbt_pkg::ST_SATURATED; return r;
    end
    ln_n = log2_fix(num);
    ln_d = log2_fix(den);
    if (ln_n < ln_d) begin
      r.temp = 18'(-KELVIN_OFS); r.st = tbt_pkg::ST_SATURATED; return r;
    end
    ln_q = ((ln_n - ln_d) * LN2_FIX + (64'd1 << 29)) >> 30;
    if (ln_q == 0) begin
      r.temp = 18'(HOT_LIMIT); r.st = tbt_pkg::ST_SATURATED; return r;
    end
    ck = (((beta * 100) << 28) + (ln_q >> 1)) / ln_q;
    if (ck > HOT_LIMIT + KELVIN_OFS) begin
      r.temp = 18'(HOT_LIMIT); r.st = tbt_pkg::ST_SATURATED; return r;
    end
    r.temp = 18'(longint'(ck) - KELVIN_OFS);
    r.st = tbt_pkg::ST_OK;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [11:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 12'd0;
    if (r < 16) return 12'hFFF;
    if (r < 24) return 12'($urandom_range(1, 15));
    return 12'($urandom);
  endfunction

  // write one register while the core is idle
  task automatic cfg_write(logic [1:0] idx, logic [29:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tbt_pkg::CFG_REFERENCE_OHMS: ref_ohms   = data & 30'hFFFFF;
      tbt_pkg::CFG_BETA_KELVIN:    beta       = data & 30'h3FFF;
      tbt_pkg::CFG_R_INFINITY:     r_inf_uohm = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // send one item, then hold it until taken
  task automatic send_pair(logic [11:0] rc, logic [11:0] tc, bit typed, reading_t typed_res);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    reference_count_i <= rc;
    thermistor_count_i <= tc;
    do @(posedge clk_i); while (in_stall_o);
    expected_readings.push_back(typed ? typed_res : thermistor_temp(rc, tc));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // drive the receiver stall in runs, with long quiet stretches
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0: begin out_stall_i <= 1'b0; stall_left <= $urandom_range(50, 150); end
        1: begin out_stall_i <= 1'b1; stall_left <= $urandom_range(10, 40); end
        2, 3, 4: begin out_stall_i <= 1'b1; stall_left <= $urandom_range(0, 3); end
        default: begin out_stall_i <= 1'b0; stall_left <= $urandom_range(0, 5); end
      endcase
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: temp %0d status %0d", temperature_centi_c_o, status_o);
      end else begin
        want = expected_readings.pop_front();
        if (temperature_centi_c_o !== want.temp || status_o !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
                     want.temp, want.st, temperature_centi_c_o, status_o);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_readings.size());
      $display("testbench: errors");
      $finish;
    end
  end

  stim_row_t directed[$];
  reading_t none_res;

  initial begin
    none_res.temp = '0;
    none_res.st = tbt_pkg::ST_OK;
    build_log2_tab();
    ref_ohms = 10000;
    beta = 3380;
    r_inf_uohm = 119286;

    // corners at the reset settings
    directed = '{
      '{12'd0,    12'd0,    1, 18'sd0,       tbt_pkg::ST_REF_ZERO},
      '{12'd0,    12'hFFF,  1, 18'sd0,       tbt_pkg::ST_REF_ZERO},
      '{12'd1,    12'd0,    1, -18'sd27315,  tbt_pkg::ST_THERM_ZERO},
      '{12'hFFF,  12'd0,    1, -18'sd27315,  tbt_pkg::ST_THERM_ZERO},
      '{12'hFFF,  12'hFFF,  0, 18'sd0, tbt_pkg::ST_OK},
      '{12'd1,    12'hFFF,  0, 18'sd0, tbt_pkg::ST_OK},
      '{12'hFFF,  12'd1,    0, 18'sd0, tbt_pkg::ST_OK},
      '{12'd1,    12'd1,    0, 18'sd0, tbt_pkg::ST_OK},
      '{12'd2048, 12'd2048, 0, 18'sd0, tbt_pkg::ST_OK},
      '{12'h800,  12'h7FF,  0, 18'sd0, tbt_pkg::ST_OK},
      '{12'h555,  12'hAAA,  0, 18'sd0, tbt_pkg::ST_OK},
      '{12'hAAA,  12'h555,  0, 18'sd0, tbt_pkg::ST_OK},
      '{12'd4000, 12'd20,   0, 18'sd0, tbt_pkg::ST_OK},
      '{12'd20,   12'd4000, 0, 18'sd0, tbt_pkg::ST_OK},
      '{12'd100,  12'd3000, 0, 18'sd0, tbt_pkg::ST_OK},
      '{12'd3000, 12'd100,  0, 18'sd0, tbt_pkg::ST_OK}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      reading_t t;
      t.temp = directed[i].temp;
      t.st = directed[i].st;
      send_pair(directed[i].rc, directed[i].tc, directed[i].typed, t);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          cfg_write(tbt_pkg::CFG_REFERENCE_OHMS, 30'd10000);
          cfg_write(tbt_pkg::CFG_BETA_KELVIN, 30'd3380);
          cfg_write(tbt_pkg::CFG_R_INFINITY, 30'd119286);
        end
        1: begin
          cfg_write(tbt_pkg::CFG_REFERENCE_OHMS, 30'd1000000);
          cfg_write(tbt_pkg::CFG_BETA_KELVIN, 30'd10000);
          cfg_write(tbt_pkg::CFG_R_INFINITY, 30'd1000000000);
        end
        2: begin
          cfg_write(tbt_pkg::CFG_REFERENCE_OHMS, 30'd1);
          cfg_write(tbt_pkg::CFG_BETA_KELVIN, 30'd1);
          cfg_write(tbt_pkg::CFG_R_INFINITY, 30'd1);
        end
        3: begin
          // zero registers, with high bits set that the widths drop
          cfg_write(tbt_pkg::CFG_REFERENCE_OHMS, 30'h3FF0_0000);
          cfg_write(tbt_pkg::CFG_BETA_KELVIN, 30'h3FFF_C000);
          cfg_write(tbt_pkg::CFG_R_INFINITY, 30'd0);
        end
        4: begin
          cfg_write(tbt_pkg::CFG_REFERENCE_OHMS, 30'h3FFF_FFFF);
          cfg_write(tbt_pkg::CFG_BETA_KELVIN, 30'h3FFF_FFFF);
          cfg_write(tbt_pkg::CFG_R_INFINITY, 30'h3FFF_FFFF);
          cfg_write(2'd3, 30'($urandom));
        end
        default: begin
          cfg_write(tbt_pkg::CFG_REFERENCE_OHMS, 30'($urandom_range(1000, 100000)));
          cfg_write(tbt_pkg::CFG_BETA_KELVIN, 30'($urandom_range(2000, 5000)));
          cfg_write(tbt_pkg::CFG_R_INFINITY, 30'($urandom_range(10000, 1000000)));
        end
      endcase
      repeat (RAND_PER_PHASE) send_pair(rand_count(), rand_count(), 0, none_res);
    end

    drain();
    $display("sent %0d items in %0d phases, checked %0d results, %0d register writes",
             items_sent, N_PHASES + 1, readings_seen, cfg_writes);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_readings.size());
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
